@@ src/rcf_pkg.sv @@
package rcf_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 16;
    localparam int STAGES_W  = 4;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_MODE   = 2'd0,
        REG_STAGES_IN_USE = 2'd1,
        REG_POLE_COEF     = 2'd2
    } cfg_reg_t;

    // One sample moving down the chain, with the previous output of the
    // stage that produced it (the highpass "previous input" of the next stage).
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] cur;
        logic signed [SAMPLE_W-1:0] prev;
    } beat_t;

    typedef struct packed {
        logic advance;
        logic hp_mode;
        logic active;
    } cell_ctl_t;

endpackage

@@ src/rcf_cell.sv @@
module rcf_cell #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  rcf_pkg::cell_ctl_t                 ctl,
    input  logic [rcf_pkg::COEF_W-1:0]         coef,
    input  rcf_pkg::beat_t                     in_beat,
    output rcf_pkg::beat_t                     out_beat
);

    localparam int SW     = rcf_pkg::SAMPLE_W;
    localparam int OP_W   = SW + 2;
    localparam int PROD_W = OP_W + rcf_pkg::COEF_W + 1;
    localparam int BASE_W = SW + COEF_FRAC_BITS;
    localparam int ACC_W  = ((PROD_W > BASE_W) ? PROD_W : BASE_W) + 1;

    localparam logic signed [ACC_W-1:0] HALF_LSB =
        ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(rcf_pkg::SAMPLE_MAX);
    localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(rcf_pkg::SAMPLE_MIN);

    logic signed [SW-1:0]     state_reg, state_next;
    rcf_pkg::beat_t           out_reg, out_next;

    logic signed [OP_W-1:0]                 lp_diff, hp_sum, mul_op;
    logic signed [rcf_pkg::COEF_W:0]        coef_s;
    logic signed [PROD_W-1:0]               prod;
    logic signed [ACC_W-1:0]                base, acc, rounded;
    logic signed [SW-1:0]                   result;

    always_comb begin
        lp_diff = OP_W'(state_reg) - OP_W'(in_beat.cur);
        hp_sum  = OP_W'(in_beat.cur) + OP_W'(state_reg) - OP_W'(in_beat.prev);
        mul_op  = ctl.hp_mode ? hp_sum : lp_diff;
        coef_s  = $signed({1'b0, coef});
        prod    = PROD_W'(mul_op) * PROD_W'(coef_s);
        base    = ctl.hp_mode ? '0 : (ACC_W'(in_beat.cur) <<< COEF_FRAC_BITS);
        acc     = base + ACC_W'(prod);
        // round half up: bias then floor
        rounded = (acc + HALF_LSB) >>> COEF_FRAC_BITS;
        if (rounded > ACC_MAX) begin
            result = rcf_pkg::SAMPLE_MAX;
        end else if (rounded < ACC_MIN) begin
            result = rcf_pkg::SAMPLE_MIN;
        end else begin
            result = rounded[SW-1:0];
        end

        state_next = state_reg;
        out_next   = out_reg;
        if (ctl.advance) begin
            out_next.valid = in_beat.valid;
            if (in_beat.valid && ctl.active) begin
                state_next    = result;
                out_next.cur  = result;
                out_next.prev = state_reg;
            end else begin
                // idle stage: pass the sample on, keep the stored output
                out_next.cur  = in_beat.cur;
                out_next.prev = in_beat.prev;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_reg.valid <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_reg.valid <= out_next.valid;
        end
        out_reg.cur  <= out_next.cur;
        out_reg.prev <= out_next.prev;
    end

    assign out_beat = out_reg;

endmodule

@@ src/rc_cascade_filter_unit.sv @@
// Cascade of up to MAX_STAGES first-order RC stages on a 24-bit signed
// sample stream, lowpass or highpass, with coefficient a = pole_coef /
// 2^COEF_FRAC_BITS; each stage rounds half up and saturates. Every stage is
// one cell holding its previous output and one multiplier, and a sample
// moves one cell per cycle, so a sample is taken every cycle, while the
// chain is not held; stages beyond stages_in_use pass the sample on
// unchanged. The whole chain holds while a result waits on m_tready.
// Configure only while no sample is in flight.
module rc_cascade_filter_unit #(
    parameter int MAX_STAGES     = 8,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  logic [rcf_pkg::CFG_IDX_W-1:0]     cfg_wr_addr,
    input  logic [rcf_pkg::CFG_W-1:0]         cfg_wr_data,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // [23:0] sample_in

    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata    // [23:0] filtered_out
);

    localparam int SW = rcf_pkg::SAMPLE_W;

    logic                                mode_reg;
    logic [rcf_pkg::STAGES_W-1:0]        stages_reg;
    logic [rcf_pkg::COEF_W-1:0]          coef_reg;
    logic signed [SW-1:0]                prev_sample_reg, prev_sample_next;

    logic                                advance;
    logic                                accept;
    rcf_pkg::beat_t                      chain [0:MAX_STAGES];
    logic [MAX_STAGES-1:0]               valid_vec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b0;
            stages_reg <= rcf_pkg::STAGES_W'(1);
            coef_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_addr)
                rcf_pkg::REG_FILTER_MODE:   mode_reg   <= cfg_wr_data[0];
                rcf_pkg::REG_STAGES_IN_USE: stages_reg <= cfg_wr_data[rcf_pkg::STAGES_W-1:0];
                rcf_pkg::REG_POLE_COEF:     coef_reg   <= cfg_wr_data[rcf_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        prev_sample_next = accept ? $signed(s_tdata) : prev_sample_reg;
        chain[0].valid   = accept;
        chain[0].cur     = $signed(s_tdata);
        chain[0].prev    = prev_sample_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_sample_reg <= '0;
        end else begin
            prev_sample_reg <= prev_sample_next;
        end
    end

    for (genvar k = 1; k <= MAX_STAGES; k++) begin : g_cell
        rcf_pkg::cell_ctl_t ctl;

        always_comb begin
            ctl.advance = advance;
            ctl.hp_mode = mode_reg;
            ctl.active  = (int'(stages_reg) >= k);
        end

        rcf_cell #(
            .COEF_FRAC_BITS(COEF_FRAC_BITS)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .coef    (coef_reg),
            .in_beat (chain[k-1]),
            .out_beat(chain[k])
        );

        assign valid_vec[k-1] = chain[k].valid;
    end

    assign m_tvalid = chain[MAX_STAGES].valid;
    assign m_tdata  = chain[MAX_STAGES].cur;

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(valid_vec))
        else $error("chain moved while output stalled");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> valid_vec[0])
        else $error("accepted beat missing from first cell");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule
